// ===== hdl/led_cc_pkg.sv =====
`timescale 1ns / 1ps

package led_cc_pkg;

  // Field widths
  localparam int CHAN_W  = 8;
  localparam int ID_W    = 8;
  localparam int GAIN_W  = 10;
  localparam int LEVEL_W = 8;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 10;

  // Default gain fraction bits
  localparam int GAIN_FRAC_DEFAULT = 8;

  // Scale factor k over 32: at most 16 + 255
  localparam int SCALE_W    = 9;
  localparam int SCALE_SHIFT = 5;
  localparam logic [SCALE_W-1:0] SCALE_UNITY = 9'd32;
  localparam logic [SCALE_W-1:0] SCALE_BASE  = 9'd16;

  // Channel count
  localparam int NUM_CHAN = 3;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_RED     = 3'd0,
    REG_GAIN_GREEN   = 3'd1,
    REG_GAIN_BLUE    = 3'd2,
    REG_DARK_LEVEL   = 3'd3,
    REG_SPREAD_LIMIT = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [GAIN_W-1:0]  RST_GAIN_RED     = 10'd307;
  localparam logic [GAIN_W-1:0]  RST_GAIN_GREEN   = 10'd128;
  localparam logic [GAIN_W-1:0]  RST_GAIN_BLUE    = 10'd154;
  localparam logic [LEVEL_W-1:0] RST_DARK_LEVEL   = 8'd64;
  localparam logic [LEVEL_W-1:0] RST_SPREAD_LIMIT = 8'd32;

  typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

endpackage

// ===== hdl/led_color_correct.sv =====
`timescale 1ns / 1ps

// Throughput: one item per cycle; five register stages move together and
// hold as one while the output is stalled with a valid result.
// Reset (rst, synchronous): all stage valid bits clear, registers return
// to gain_red=307, gain_green=128, gain_blue=154, dark_level=64, spread_limit=32.
module led_color_correct #(
  parameter int GAIN_FRACTION_BITS = led_cc_pkg::GAIN_FRAC_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  // config write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [led_cc_pkg::IDX_W-1:0]   cfg_index,
  input  logic [led_cc_pkg::DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [led_cc_pkg::ID_W-1:0]    led_id,
  input  logic [led_cc_pkg::CHAN_W-1:0]  red,
  input  logic [led_cc_pkg::CHAN_W-1:0]  green,
  input  logic [led_cc_pkg::CHAN_W-1:0]  blue,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [led_cc_pkg::ID_W-1:0]    out_id,
  output logic [led_cc_pkg::CHAN_W-1:0]  out_red,
  output logic [led_cc_pkg::CHAN_W-1:0]  out_green,
  output logic [led_cc_pkg::CHAN_W-1:0]  out_blue
);

  localparam int CW   = led_cc_pkg::CHAN_W;
  localparam int NC   = led_cc_pkg::NUM_CHAN;
  localparam int KW   = led_cc_pkg::SCALE_W;
  localparam int GW   = led_cc_pkg::GAIN_W;
  localparam int LW   = led_cc_pkg::LEVEL_W;
  localparam int SUMW = CW + 2;
  localparam int P1W  = CW + KW;
  localparam int P2W  = P1W + GW;
  localparam int SH   = led_cc_pkg::SCALE_SHIFT + GAIN_FRACTION_BITS;
  localparam logic [P2W-1:0] SAT_MAX = P2W'((1 << CW) - 1);

  // configuration registers
  logic [NC-1:0][GW-1:0] gain;
  logic [LW-1:0]         dark_level;
  logic [LW-1:0]         spread_limit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain[0]      <= led_cc_pkg::RST_GAIN_RED;
      gain[1]      <= led_cc_pkg::RST_GAIN_GREEN;
      gain[2]      <= led_cc_pkg::RST_GAIN_BLUE;
      dark_level   <= led_cc_pkg::RST_DARK_LEVEL;
      spread_limit <= led_cc_pkg::RST_SPREAD_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        led_cc_pkg::REG_GAIN_RED:     gain[0]      <= cfg_data[GW-1:0];
        led_cc_pkg::REG_GAIN_GREEN:   gain[1]      <= cfg_data[GW-1:0];
        led_cc_pkg::REG_GAIN_BLUE:    gain[2]      <= cfg_data[GW-1:0];
        led_cc_pkg::REG_DARK_LEVEL:   dark_level   <= cfg_data[LW-1:0];
        led_cc_pkg::REG_SPREAD_LIMIT: spread_limit <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless the output holds a stalled result
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic v1, v2, v3, v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // stage 1: max, min and sum
  led_cc_pkg::rgb_t    in_rgb;
  logic [CW-1:0]       hi_c, lo_c;
  logic [led_cc_pkg::ID_W-1:0] s1_id;
  led_cc_pkg::rgb_t    s1_rgb;
  logic [CW-1:0]       s1_hi, s1_lo;
  logic [SUMW-1:0]     s1_sum;

  assign in_rgb = {blue, green, red};

  always_comb begin
    hi_c = red;
    lo_c = red;
    if (green > hi_c) hi_c = green;
    if (blue > hi_c)  hi_c = blue;
    if (green < lo_c) lo_c = green;
    if (blue < lo_c)  lo_c = blue;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_id  <= led_id;
      s1_rgb <= in_rgb;
      s1_hi  <= hi_c;
      s1_lo  <= lo_c;
      s1_sum <= SUMW'(red) + SUMW'(green) + SUMW'(blue);
    end
  end

  // stage 2: thresholds pick the scale
  logic [CW-1:0]   spread;
  logic [SUMW-1:0] dark3;
  logic            adjust;
  logic [led_cc_pkg::ID_W-1:0] s2_id;
  led_cc_pkg::rgb_t s2_rgb;
  logic [KW-1:0]   s2_k;

  assign spread = s1_hi - s1_lo;
  assign dark3  = {1'b0, dark_level, 1'b0} + SUMW'(dark_level);
  assign adjust = (s1_sum < dark3) && (spread < spread_limit);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_id  <= s1_id;
      s2_rgb <= s1_rgb;
      s2_k   <= adjust ? (led_cc_pkg::SCALE_BASE + KW'(spread))
                       : led_cc_pkg::SCALE_UNITY;
    end
  end

  // stage 3: channel times scale
  logic [led_cc_pkg::ID_W-1:0] s3_id;
  logic [NC-1:0][P1W-1:0] s3_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_id <= s2_id;
      for (int i = 0; i < NC; i++) begin
        s3_p[i] <= P1W'(s2_rgb[i]) * P1W'(s2_k);
      end
    end
  end

  // stage 4: times channel gain
  logic [led_cc_pkg::ID_W-1:0] s4_id;
  logic [NC-1:0][P2W-1:0] s4_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_id <= s3_id;
      for (int i = 0; i < NC; i++) begin
        s4_p[i] <= P2W'(s3_p[i]) * P2W'(gain[i]);
      end
    end
  end

  // stage 5: truncate and saturate into the output register
  logic [NC-1:0][P2W-1:0] q;
  led_cc_pkg::rgb_t       sat;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      q[i]   = s4_p[i] >> SH;
      sat[i] = (q[i] > SAT_MAX) ? {CW{1'b1}} : q[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_id    <= s4_id;
      out_red   <= sat[0];
      out_green <= sat[1];
      out_blue  <= sat[2];
    end
  end

  // checks
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (s2_k >= led_cc_pkg::SCALE_BASE))
    else $error("scale below base");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable({v1, v2, v3, v4, s4_p}))
    else $error("pipeline moved during stall");

  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !v1 && !v4)
    else $error("valid bits not cleared by reset");

  a_p1_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> (s3_p[0] <= P1W'(255 * 271)) && (s3_p[1] <= P1W'(255 * 271))
           && (s3_p[2] <= P1W'(255 * 271)))
    else $error("scaled channel out of range");

endmodule

// ===== bench/led_color_correct_test.sv =====
`timescale 1ns / 1ps

module led_color_correct_test;

  localparam int CHAN_W            = led_cc_pkg::CHAN_W;
  localparam int ID_W              = led_cc_pkg::ID_W;
  localparam int GAIN_W            = led_cc_pkg::GAIN_W;
  localparam int LEVEL_W           = led_cc_pkg::LEVEL_W;
  localparam int IDX_W             = led_cc_pkg::IDX_W;
  localparam int DATA_W            = led_cc_pkg::DATA_W;
  localparam int SCALE_W           = led_cc_pkg::SCALE_W;
  localparam int PROD_W            = CHAN_W + SCALE_W + GAIN_W;
  localparam int GAIN_FRAC         = led_cc_pkg::GAIN_FRAC_DEFAULT;
  localparam int LATENCY           = 5;
  localparam int CYCLE_LIMIT       = 200000;
  localparam int ITEMS_PER_SETTING = 130;
  localparam int NUM_SETTINGS      = 5;
  localparam int HOLD_CYCLES       = 60;
  localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};
  // Indexes past the register list; writes there must not land anywhere
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } led_color_t;

  typedef struct {
    logic [GAIN_W-1:0]  gain_r;
    logic [GAIN_W-1:0]  gain_g;
    logic [GAIN_W-1:0]  gain_b;
    logic [LEVEL_W-1:0] dark;
    logic [LEVEL_W-1:0] spread_lim;
  } color_setting_t;

  // Color correction predictor and queue of corrected colors still owed
  class color_board;
    logic [GAIN_W-1:0]  gain_r, gain_g, gain_b;
    logic [LEVEL_W-1:0] dark, spread_lim;
    led_color_t         corrected_q[$];
    int                 errors;
    int                 transfers;
    int                 adjusted;

    function new();
      gain_r     = led_cc_pkg::RST_GAIN_RED;
      gain_g     = led_cc_pkg::RST_GAIN_GREEN;
      gain_b     = led_cc_pkg::RST_GAIN_BLUE;
      dark       = led_cc_pkg::RST_DARK_LEVEL;
      spread_lim = led_cc_pkg::RST_SPREAD_LIMIT;
      errors     = 0;
      transfers  = 0;
      adjusted   = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        led_cc_pkg::REG_GAIN_RED:     gain_r     = data[GAIN_W-1:0];
        led_cc_pkg::REG_GAIN_GREEN:   gain_g     = data[GAIN_W-1:0];
        led_cc_pkg::REG_GAIN_BLUE:    gain_b     = data[GAIN_W-1:0];
        led_cc_pkg::REG_DARK_LEVEL:   dark       = data[LEVEL_W-1:0];
        led_cc_pkg::REG_SPREAD_LIMIT: spread_lim = data[LEVEL_W-1:0];
        default: ;
      endcase
    endfunction

    // floor(ch * k * gain / 2^(5+frac)), clipped to full scale
    function logic [CHAN_W-1:0] scale_chan(logic [CHAN_W-1:0] ch, logic [SCALE_W-1:0] k,
                                           logic [GAIN_W-1:0] gain);
      logic [PROD_W-1:0] prod;
      prod = PROD_W'(ch) * PROD_W'(k) * PROD_W'(gain);
      prod = prod >> (led_cc_pkg::SCALE_SHIFT + GAIN_FRAC);
      return (prod > CHAN_MAX) ? CHAN_MAX : prod[CHAN_W-1:0];
    endfunction

    function led_color_t correct_color(led_color_t c);
      logic [CHAN_W-1:0]  hi, lo;
      logic [CHAN_W+1:0]  sum;
      logic [SCALE_W-1:0] k;
      led_color_t         res;
      hi = c.r;
      lo = c.r;
      if (c.g > hi) hi = c.g;
      if (c.b > hi) hi = c.b;
      if (c.g < lo) lo = c.g;
      if (c.b < lo) lo = c.b;
      sum = {2'b00, c.r} + {2'b00, c.g} + {2'b00, c.b};
      k = led_cc_pkg::SCALE_UNITY;
      // dim, washed-out colors get scaled by (16+spread)/32
      if (sum < 3 * dark && (hi - lo) < spread_lim) begin
        k = led_cc_pkg::SCALE_BASE + {1'b0, hi - lo};
        adjusted++;
      end
      res.id = c.id;
      res.r  = scale_chan(c.r, k, gain_r);
      res.g  = scale_chan(c.g, k, gain_g);
      res.b  = scale_chan(c.b, k, gain_b);
      return res;
    endfunction

    function void note_input(led_color_t c);
      corrected_q.push_back(correct_color(c));
      transfers++;
    endfunction

    function int pending();
      return corrected_q.size();
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("%0t mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(led_color_t got);
      led_color_t want;
      if (corrected_q.size() == 0) begin
        report_mismatch($sformatf("result id %0d with nothing outstanding", got.id));
        return;
      end
      want = corrected_q.pop_front();
      if (got.id !== want.id)
        report_mismatch($sformatf("out_id got %0d want %0d", got.id, want.id));
      if (got.r !== want.r)
        report_mismatch($sformatf("out_red got %0d want %0d (id %0d)", got.r, want.r, want.id));
      if (got.g !== want.g)
        report_mismatch($sformatf("out_green got %0d want %0d (id %0d)", got.g, want.g, want.id));
      if (got.b !== want.b)
        report_mismatch($sformatf("out_blue got %0d want %0d (id %0d)", got.b, want.b, want.id));
    endtask
  endclass

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]  cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [ID_W-1:0]    led_id    = '0;
  logic [CHAN_W-1:0]  red       = '0;
  logic [CHAN_W-1:0]  green     = '0;
  logic [CHAN_W-1:0]  blue      = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ID_W-1:0]    out_id;
  logic [CHAN_W-1:0]  out_red;
  logic [CHAN_W-1:0]  out_green;
  logic [CHAN_W-1:0]  out_blue;

  color_board board = new();
  int cycle_count    = 0;
  int send_idle_pct  = 11;
  int recv_stall_pct = 64;
  int hold_reqs      = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  led_color_correct #(
    .GAIN_FRACTION_BITS(GAIN_FRAC)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .led_id    (led_id),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_id    (out_id),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

  always #5 clk = ~clk;

  // Output side: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Result check on each output transfer; watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** led_color_correct: FAILED **");
      $finish;
    end else if (!rst && out_valid && !out_stall) begin
      board.check_result({out_id, out_red, out_green, out_blue});
    end
  end

  // Offer one color; called and returns at a falling edge
  task automatic send_color(led_color_t c);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_valid = 1'b1;
    led_id   = c.id;
    red      = c.r;
    green    = c.g;
    blue     = c.b;
    do @(posedge clk); while (in_stall);
    board.note_input(c);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper data bits of the 8-bit registers carry junk that must be dropped
  task automatic load_setting(color_setting_t s);
    logic [DATA_W-1:0] junk;
    junk = DATA_W'($urandom);
    write_reg(led_cc_pkg::REG_GAIN_RED, s.gain_r);
    write_reg(led_cc_pkg::REG_GAIN_GREEN, s.gain_g);
    write_reg(led_cc_pkg::REG_GAIN_BLUE, s.gain_b);
    write_reg(led_cc_pkg::REG_DARK_LEVEL, {junk[DATA_W-1:LEVEL_W], s.dark});
    write_reg(led_cc_pkg::REG_SPREAD_LIMIT, {~junk[DATA_W-1:LEVEL_W], s.spread_lim});
    write_reg(REG_SPARE_LO, junk);
    write_reg(REG_SPARE_HI, ~junk);
  endtask

  // Wait out all owed results plus the pipeline depth
  task automatic drain();
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(negedge clk);
  endtask

  function automatic logic [CHAN_W-1:0] near_level(int base, int width);
    int v;
    v = base + $urandom_range(width);
    return (v > CHAN_MAX) ? CHAN_MAX : v[CHAN_W-1:0];
  endfunction

  // Dim, low-spread colors around the current thresholds, full-scale corners or random colors
  function automatic led_color_t random_color();
    led_color_t c;
    int         base, width;
    c = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        base  = $urandom_range(board.dark);
        width = $urandom_range(board.spread_lim + 1);
        c.r   = near_level(base, width);
        c.g   = near_level(base, width);
        c.b   = near_level(base, width);
      end
      4, 5: begin
        c.r = $urandom_range(1) ? CHAN_MAX : '0;
        c.g = $urandom_range(1) ? CHAN_MAX : '0;
        c.b = $urandom_range(1) ? CHAN_MAX : '0;
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    color_setting_t settings[NUM_SETTINGS];
    led_color_t     directed[$];

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed colors under reset register values
    directed.push_back('{8'd0,   8'd0,   8'd0,   8'd0});
    directed.push_back('{8'd255, 8'd255, 8'd255, 8'd255});
    directed.push_back('{8'd1,   8'd255, 8'd0,   8'd0});
    directed.push_back('{8'd2,   8'd0,   8'd255, 8'd0});
    directed.push_back('{8'd3,   8'd0,   8'd0,   8'd255});
    directed.push_back('{8'd85,  8'd10,  8'd10,  8'd10});
    // sum just under / at 3*dark_level
    directed.push_back('{8'd170, 8'd63,  8'd64,  8'd64});
    directed.push_back('{8'd171, 8'd64,  8'd64,  8'd64});
    // spread just under / at the limit
    directed.push_back('{8'd4,   8'd40,  8'd71,  8'd40});
    directed.push_back('{8'd5,   8'd40,  8'd72,  8'd40});
    directed.push_back('{8'd6,   8'd0,   8'd31,  8'd0});
    directed.push_back('{8'd7,   8'd85,  8'd170, 8'd85});
    directed.push_back('{8'd8,   8'd170, 8'd85,  8'd170});
    directed.push_back('{8'd9,   8'd1,   8'd1,   8'd1});
    directed.push_back('{8'd10,  8'd254, 8'd254, 8'd254});
    directed.push_back('{8'd128, 8'd128, 8'd128, 8'd128});
    directed.push_back('{8'd127, 8'd128, 8'd0,   8'd200});
    foreach (directed[i]) send_color(directed[i]);

    settings[0] = '{10'd512, 10'd300, 10'd64, 8'd100, 8'd48};
    // zero thresholds never adjust; zero gains give black
    settings[1] = '{10'd0, 10'd0, 10'd0, 8'd0, 8'd0};
    // full gains and thresholds: scale above one, saturation
    settings[2] = '{10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255};
    settings[3] = '{10'd256, 10'd256, 10'd256, 8'd128, 8'd16};
    settings[4].gain_r     = GAIN_W'($urandom);
    settings[4].gain_g     = GAIN_W'($urandom);
    settings[4].gain_b     = GAIN_W'($urandom);
    settings[4].dark       = LEVEL_W'($urandom);
    settings[4].spread_lim = LEVEL_W'($urandom);

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      drain();
      load_setting(settings[s]);
      if (s < 2) begin
        send_idle_pct  = 11;
        recv_stall_pct = 64;
      end else if (s < 4) begin
        send_idle_pct  = 64;
        recv_stall_pct = 11;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      for (int i = 0; i < ITEMS_PER_SETTING; i++) begin
        // sender pause: let the pipe empty completely
        if (s == 0 && i == 60) drain();
        // long output hold-off while input keeps coming
        if (s == NUM_SETTINGS - 1 && i == 40) begin
          @(posedge clk);
          hold_reqs++;
          @(negedge clk);
        end
        send_color(random_color());
      end
    end

    drain();
    repeat (LATENCY * 4) @(posedge clk);
    $display("Ran %0d color transfers through reset values and %0d register settings,",
             board.transfers, NUM_SETTINGS);
    $display("%0d of them in the dim low-spread scaling path.", board.adjusted);
    if (board.errors == 0) begin
      $display("** led_color_correct: PASSED **");
    end else begin
      $display("** led_color_correct: FAILED **");
    end
    $finish;
  end

endmodule
